### src/rmsbl_pkg.sv
package rmsbl_pkg;

  // field widths fixed by the item formats
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = 47;
  localparam int CNT_W    = 17;
  localparam int LEVEL_W  = 16;

  // block queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // input request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_present;
    logic                       block_end;
  } in_item_t;

  // result request
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   block_count;
    logic               overflowed;
  } out_item_t;

  // closed block handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } blk_sum_t;

  // queue status seen by front and back
  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
    logic              not_empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SQRT,
    B_OUT
  } back_state_t;

endpackage

### src/rms_block_level.sv
// Channel  | Ports                    | Accepted when
// ---------+--------------------------+-----------------------
// input    | push, full, in_data      | push && !full
// result   | empty, pop, out_data     | pop && !empty
//
// The front takes one input request per cycle while full is low and squares
// it in one stage. A closing request hands the block sums to a two-entry
// queue; full rises while that queue, counting a closing request still in the
// square stage, has no room. The back pops a block, runs a restoring divide
// and 24 root steps unless it is empty, then waits for a free result
// register. Reset (synchronous, rst_n low) clears sums and queues.
module rms_block_level #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  rmsbl_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output rmsbl_pkg::out_item_t out_data
);
  import rmsbl_pkg::*;

  logic        q_push;
  blk_sum_t    q_wr_data;
  logic        q_pop;
  blk_sum_t    q_rd_data;
  queue_stat_t q_stat;

  rmsbl_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  rmsbl_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wr_data),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .stat   (q_stat)
  );

  rmsbl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule

### src/rmsbl_front.sv
module rmsbl_front #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  rmsbl_pkg::in_item_t   in_data,
  input  rmsbl_pkg::queue_stat_t q_stat,
  output logic                  q_push,
  output rmsbl_pkg::blk_sum_t   q_data
);
  import rmsbl_pkg::*;

  // sample decode: only the low SAMPLE_BITS of the field count
  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] RAW_MASK = SAMPLE_W'((64'(1) << EFF_BITS) - 64'(1));
  localparam bit SIGNED_IN = (SAMPLE_BITS <= SAMPLE_W);
  localparam int SIGN_POS  = SIGNED_IN ? (SAMPLE_BITS - 1) : 0;

  logic                accept;
  logic                pend_end;
  logic [QCNT_W:0]     occ;
  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;

  // square stage
  logic            s_valid_r, s_valid_nxt;
  logic            s_present_r;
  logic            s_end_r;
  logic [SQ_W-1:0] s_sq_r;

  // block accumulators
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic             ovf_upd;
  logic             room;

  // full counts a closing request already in the square stage
  assign pend_end = s_valid_r & s_end_r;
  assign occ      = {1'b0, q_stat.cnt} + {{QCNT_W{1'b0}}, pend_end};
  assign full     = (occ >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept   = push & ~full;

  // magnitude of the sample
  assign raw = unsigned'(in_data.sample) & RAW_MASK;
  assign mag = (SIGNED_IN && raw[SIGN_POS]) ? (((~raw) + 1'b1) & RAW_MASK) : raw;

  assign s_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_present_r <= in_data.sample_present;
      s_end_r     <= in_data.block_end;
      s_sq_r      <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // accumulate, close the block into the queue
  assign room = (32'(cnt_r) < 32'(MAX_SAMPLES));

  always_comb begin
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    ovf_upd = ovf_r;
    if (s_valid_r && s_present_r) begin
      if (room) begin
        sum_upd = sum_r + SUM_W'(s_sq_r);
        cnt_upd = cnt_r + 1'b1;
      end else begin
        ovf_upd = 1'b1;
      end
    end
    q_push       = pend_end;
    q_data.sum   = sum_upd;
    q_data.count = cnt_upd;
    q_data.ovf   = ovf_upd;
    if (pend_end) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      sum_nxt = sum_upd;
      cnt_nxt = cnt_upd;
      ovf_nxt = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

### src/rmsbl_fifo.sv
module rmsbl_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  rmsbl_pkg::blk_sum_t    wr_data,
  input  logic                   rd_en,
  output rmsbl_pkg::blk_sum_t    rd_data,
  output rmsbl_pkg::queue_stat_t stat
);
  import rmsbl_pkg::*;

  blk_sum_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_rd;

  assign do_rd          = rd_en & (cnt_r != '0);
  assign rd_data        = mem_r[rd_ptr_r];
  assign stat.cnt       = cnt_r;
  assign stat.not_empty = (cnt_r != '0);

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // front must never write a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < QCNT_W'(QUEUE_DEPTH)) || do_rd)
    else $error("block queue overrun");
`endif

endmodule

### src/rmsbl_back.sv
module rmsbl_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmsbl_pkg::queue_stat_t q_stat,
  input  rmsbl_pkg::blk_sum_t    q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output rmsbl_pkg::out_item_t   out_data
);
  import rmsbl_pkg::*;

  localparam int RW       = SUM_W + 1;
  localparam int IT_W     = $clog2(SUM_W);
  localparam int DIV_LAST = SUM_W - 1;
  localparam int SQ_TOP   = ((SUM_W - 1) / 2) * 2;

  back_state_t      state_r, state_nxt;
  logic [SUM_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [RW-1:0]    x_r, x_nxt;
  logic [RW-1:0]    root_r, root_nxt;
  logic [RW-1:0]    bit_r, bit_nxt;
  logic [CNT_W-1:0] cnt_keep_r, cnt_keep_nxt;
  logic             ovf_keep_r, ovf_keep_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [CNT_W:0]   rs;
  logic [CNT_W:0]   rs_diff;
  logic             qb;
  logic [RW-1:0]    trial;
  logic             load;

  assign empty    = ~out_valid_r;
  assign out_data = out_r;

  // restoring divide step and square root step
  assign rs      = {rem_r, n_r[SUM_W-1]};
  assign rs_diff = rs - {1'b0, d_r};
  assign qb      = (rs >= {1'b0, d_r});
  assign trial   = root_r + bit_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    it_nxt        = it_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    cnt_keep_nxt  = cnt_keep_r;
    ovf_keep_nxt  = ovf_keep_r;
    level_nxt     = level_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_stat.not_empty) begin
          q_pop        = 1'b1;
          cnt_keep_nxt = q_data.count;
          ovf_keep_nxt = q_data.ovf;
          if (q_data.count == '0) begin
            level_nxt = '0;
            state_nxt = B_OUT;
          end else begin
            n_nxt     = q_data.sum;
            d_nxt     = q_data.count;
            rem_nxt   = '0;
            it_nxt    = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt = qb ? rs_diff[CNT_W-1:0] : rs[CNT_W-1:0];
        n_nxt   = {n_r[SUM_W-2:0], qb};
        it_nxt  = it_r + 1'b1;
        if (it_r == IT_W'(DIV_LAST)) begin
          x_nxt     = {1'b0, n_r[SUM_W-2:0], qb};
          root_nxt  = '0;
          bit_nxt   = RW'(1) << SQ_TOP;
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        if (x_r >= trial) begin
          x_nxt    = x_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == RW'(1)) begin
          level_nxt = root_nxt[LEVEL_W-1:0];
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || pop) begin
          load                = 1'b1;
          out_nxt.level       = level_r;
          out_nxt.block_count = cnt_keep_r;
          out_nxt.overflowed  = ovf_keep_r;
          state_nxt           = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // result register: held until popped
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    it_r       <= it_nxt;
    x_r        <= x_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    cnt_keep_r <= cnt_keep_nxt;
    ovf_keep_r <= ovf_keep_nxt;
    level_r    <= level_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  // empty blocks bypass the divider
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (d_r != '0))
    else $error("divide by zero count");

  // root step walks one power of four at a time
  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQRT) |-> $onehot(bit_r))
    else $error("sqrt step bit lost");

  // an empty block reports level zero
  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.block_count == '0)) |-> (out_r.level == '0))
    else $error("nonzero level for empty block");
`endif

endmodule
